[rtl/core/pcbqh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcbqh_pkg: shared types and constants of the base/quality histogram
// Sizes, codes, the command word that travels from front to back, and the
// address and counter helpers.
// ----------------------------------------------------------------------------
package pcbqh_pkg;

	localparam int MAX_LEN        = 256;
	localparam int MAX_QUAL_SCORE = 63;
	localparam int COUNT_WIDTH    = 32;

	localparam int NQ       = MAX_QUAL_SCORE + 1;
	localparam int NBASE    = 5;
	localparam int LW       = 3;                       // lane (base code) width
	localparam int PW       = $clog2(MAX_LEN + 1);     // position / length width
	localparam int QW       = $clog2(NQ);              // quality score width
	localparam int BQ_ROWS  = 2 * MAX_LEN * NQ;        // one row holds all five bases
	localparam int BQ_AW    = $clog2(BQ_ROWS);
	localparam int LH_DEPTH = 2 * (MAX_LEN + 1);
	localparam int LH_AW    = $clog2(LH_DEPTH);
	localparam int YW       = 48;
	localparam int RW       = 32;
	localparam int CLR_ROWS = (BQ_ROWS > LH_DEPTH) ? BQ_ROWS : LH_DEPTH;
	localparam int CLR_AW   = $clog2(CLR_ROWS);
	localparam int QDEPTH   = 4;
	localparam int QAW      = $clog2(QDEPTH);

	localparam logic [7:0] QUAL_OFFSET_RST = 8'd33;

	localparam logic [LW-1:0] BASE_N = 3'd0;
	localparam logic [LW-1:0] BASE_A = 3'd1;
	localparam logic [LW-1:0] BASE_C = 3'd2;
	localparam logic [LW-1:0] BASE_G = 3'd3;
	localparam logic [LW-1:0] BASE_T = 3'd4;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [NBASE-1:0][COUNT_WIDTH-1:0] row_t;

	typedef enum logic [1:0] {
		OP_BASE = 2'd0,
		OP_END  = 2'd1,
		OP_QBQ  = 2'd2,
		OP_QLEN = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_BASE  = 3'd1,
		ST_BAD_QUAL  = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_BAD_QUERY = 3'd4
	} status_t;

	// what the back end does with the memories
	typedef enum logic [2:0] {
		K_NONE   = 3'd0,
		K_BQ_INC = 3'd1,
		K_LH_INC = 3'd2,
		K_BQ_RD  = 3'd3,
		K_LH_RD  = 3'd4
	} kind_t;

	typedef struct packed {
		status_t            status;
		kind_t              kind;
		logic [BQ_AW-1:0]   bq_row;
		logic [LW-1:0]      lane;
		logic [LH_AW-1:0]   lh_addr;
		logic [YW-1:0]      yield;
		logic [RW-1:0]      reads;
	} cmd_t;

	function automatic logic [BQ_AW-1:0] bq_row_of(input logic e,
			input logic [PW-1:0] cyc, input logic [QW-1:0] q);
		logic [BQ_AW-1:0] r;
		r = BQ_AW'(e) * BQ_AW'(MAX_LEN);
		r = (r + BQ_AW'(cyc)) * BQ_AW'(NQ);
		return r + BQ_AW'(q);
	endfunction

	function automatic logic [LH_AW-1:0] lh_addr_of(input logic e,
			input logic [PW-1:0] len);
		logic [LH_AW-1:0] r;
		r = e ? LH_AW'(MAX_LEN + 1) : '0;
		return r + LH_AW'(len);
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

endpackage
`default_nettype wire

[rtl/core/pcbqh_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcbqh_ram: generic simple dual-port RAM
// One write port, one read port with registered data; read-first on a
// same-address collision.
// ----------------------------------------------------------------------------
module pcbqh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/pcbqh_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcbqh_front: item decode and per-read state
// Decodes base and quality, checks errors, keeps position, read yield,
// running totals and the read count, and issues memory commands.
// ----------------------------------------------------------------------------
module pcbqh_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [7:0]            cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            opcode,
	input  wire logic                  read_end,
	input  wire logic [7:0]            base_char,
	input  wire logic [7:0]            qual_char,
	input  wire logic [7:0]            query_cycle,
	input  wire logic [5:0]            query_quality,
	input  wire logic [2:0]            query_base,
	input  wire logic [8:0]            query_length,
	input  wire logic                  clearing,
	output logic                       push_valid,
	input  wire logic                  push_ready,
	output pcbqh_pkg::cmd_t            push_cmd
);

	logic [7:0]                   qoff_q;
	logic [pcbqh_pkg::PW-1:0]     pos_q   [2];
	logic [pcbqh_pkg::PW-1:0]     good_q  [2];
	logic [pcbqh_pkg::YW-1:0]     yield_q [2];
	logic [pcbqh_pkg::RW-1:0]     reads_q;

	logic                         fire;
	logic                         upd;
	logic                         bad_base;
	logic [pcbqh_pkg::LW-1:0]     lane;
	logic [8:0]                   qdiff;
	logic                         bad_qual;
	logic [pcbqh_pkg::PW-1:0]     pos;
	logic [pcbqh_pkg::PW-1:0]     good;
	logic [pcbqh_pkg::YW:0]       ysum;
	logic [pcbqh_pkg::PW-1:0]     pos_nx;
	logic [pcbqh_pkg::PW-1:0]     good_nx;
	logic [pcbqh_pkg::YW-1:0]     yield_nx;
	logic [pcbqh_pkg::RW-1:0]     reads_nx;
	pcbqh_pkg::cmd_t              cmd;

	assign in_ready   = !clearing && push_ready;
	assign fire       = in_valid && in_ready;
	assign push_valid = in_valid && !clearing;
	assign push_cmd   = cmd;

	always_comb begin
		bad_base = 1'b0;
		lane     = pcbqh_pkg::BASE_N;
		case (base_char)
			"N", "n": lane = pcbqh_pkg::BASE_N;
			"A", "a": lane = pcbqh_pkg::BASE_A;
			"C", "c": lane = pcbqh_pkg::BASE_C;
			"G", "g": lane = pcbqh_pkg::BASE_G;
			"T", "t": lane = pcbqh_pkg::BASE_T;
			default:  bad_base = 1'b1;
		endcase
	end

	always_comb begin
		qdiff    = {1'b0, qual_char} - {1'b0, qoff_q};
		bad_qual = qdiff[8] || (qdiff[7:0] > 8'(pcbqh_pkg::MAX_QUAL_SCORE));
		pos      = pos_q[read_end];
		good     = good_q[read_end];
		ysum     = {1'b0, yield_q[read_end]} + (pcbqh_pkg::YW + 1)'(good);

		pos_nx   = pos;
		good_nx  = good;
		yield_nx = yield_q[read_end];
		reads_nx = reads_q;
		upd      = 1'b0;

		cmd         = '0;
		cmd.status  = pcbqh_pkg::ST_OK;
		cmd.kind    = pcbqh_pkg::K_NONE;

		case (pcbqh_pkg::op_t'(opcode))
			pcbqh_pkg::OP_BASE: begin
				if (bad_base) begin
					cmd.status = pcbqh_pkg::ST_BAD_BASE;
				end else if (bad_qual) begin
					cmd.status = pcbqh_pkg::ST_BAD_QUAL;
				end else if (pos >= pcbqh_pkg::PW'(pcbqh_pkg::MAX_LEN)) begin
					cmd.status = pcbqh_pkg::ST_TOO_LONG;
				end else begin
					cmd.kind   = pcbqh_pkg::K_BQ_INC;
					cmd.bq_row = pcbqh_pkg::bq_row_of(read_end, pos,
						qdiff[pcbqh_pkg::QW-1:0]);
					cmd.lane   = lane;
					upd        = 1'b1;
					pos_nx     = pos + pcbqh_pkg::PW'(1);
					good_nx    = good + pcbqh_pkg::PW'(lane != pcbqh_pkg::BASE_N);
				end
			end
			pcbqh_pkg::OP_END: begin
				// length never passes MAX_LEN, so no clamp is needed
				cmd.kind    = pcbqh_pkg::K_LH_INC;
				cmd.lh_addr = pcbqh_pkg::lh_addr_of(read_end, pos);
				upd         = 1'b1;
				pos_nx      = '0;
				good_nx     = '0;
				yield_nx    = ysum[pcbqh_pkg::YW] ? '1 : ysum[pcbqh_pkg::YW-1:0];
				if (!read_end && !(&reads_q)) begin
					reads_nx = reads_q + pcbqh_pkg::RW'(1);
				end
			end
			pcbqh_pkg::OP_QBQ: begin
				if (32'(query_cycle) >= 32'(pcbqh_pkg::MAX_LEN) ||
						32'(query_quality) > 32'(pcbqh_pkg::MAX_QUAL_SCORE) ||
						query_base > pcbqh_pkg::BASE_T) begin
					cmd.status = pcbqh_pkg::ST_BAD_QUERY;
				end else begin
					cmd.kind   = pcbqh_pkg::K_BQ_RD;
					cmd.bq_row = pcbqh_pkg::bq_row_of(read_end,
						pcbqh_pkg::PW'(query_cycle), pcbqh_pkg::QW'(query_quality));
					cmd.lane   = query_base;
				end
			end
			pcbqh_pkg::OP_QLEN: begin
				if (32'(query_length) > 32'(pcbqh_pkg::MAX_LEN)) begin
					cmd.status = pcbqh_pkg::ST_BAD_QUERY;
				end else begin
					cmd.kind    = pcbqh_pkg::K_LH_RD;
					cmd.lh_addr = pcbqh_pkg::lh_addr_of(read_end,
						pcbqh_pkg::PW'(query_length));
				end
			end
			default: begin
				cmd.status = pcbqh_pkg::ST_OK;
			end
		endcase

		cmd.yield = yield_nx;
		cmd.reads = reads_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qoff_q     <= pcbqh_pkg::QUAL_OFFSET_RST;
			pos_q[0]   <= '0;
			pos_q[1]   <= '0;
			good_q[0]  <= '0;
			good_q[1]  <= '0;
			yield_q[0] <= '0;
			yield_q[1] <= '0;
			reads_q    <= '0;
		end else begin
			if (cfg_we) begin
				qoff_q <= cfg_wdata;
			end
			if (fire && upd) begin
				pos_q[read_end]   <= pos_nx;
				good_q[read_end]  <= good_nx;
				yield_q[read_end] <= yield_nx;
				reads_q           <= reads_nx;
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q[0] <= pcbqh_pkg::PW'(pcbqh_pkg::MAX_LEN) &&
		pos_q[1] <= pcbqh_pkg::PW'(pcbqh_pkg::MAX_LEN))
		else $error("read position beyond maximum length");

	a_good_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		good_q[0] <= pos_q[0] && good_q[1] <= pos_q[1])
		else $error("read yield exceeds bases seen");
`endif

endmodule
`default_nettype wire

[rtl/core/pcbqh_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcbqh_fifo: command queue
// Short register FIFO between the decode front and the memory back end.
// ----------------------------------------------------------------------------
module pcbqh_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire pcbqh_pkg::cmd_t push_cmd,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output pcbqh_pkg::cmd_t      pop_cmd
);

	pcbqh_pkg::cmd_t           ent_q [pcbqh_pkg::QDEPTH];
	logic [pcbqh_pkg::QAW-1:0] wr_ptr_q;
	logic [pcbqh_pkg::QAW-1:0] rd_ptr_q;
	logic [pcbqh_pkg::QAW:0]   cnt_q;
	logic                      push;
	logic                      pop;

	assign push_ready = cnt_q != (pcbqh_pkg::QAW + 1)'(pcbqh_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pcbqh_pkg::QAW'(pcbqh_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + pcbqh_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pcbqh_pkg::QAW'(pcbqh_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + pcbqh_pkg::QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (pcbqh_pkg::QAW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (pcbqh_pkg::QAW + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/pcbqh_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcbqh_back: count memories and result stage
// Clears both memories after reset, then runs read-modify-write of bins
// with a one-entry write forward, and holds the result register.
// ----------------------------------------------------------------------------
module pcbqh_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pop_valid,
	output logic                        pop_ready,
	input  wire pcbqh_pkg::cmd_t        pop_cmd,
	output logic                        clearing,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [2:0]                  status,
	output logic [31:0]                 count_value,
	output logic [pcbqh_pkg::YW-1:0]    total_yield,
	output logic [pcbqh_pkg::RW-1:0]    read_count
);

	localparam int BQ_W = pcbqh_pkg::NBASE * pcbqh_pkg::COUNT_WIDTH;

	logic                         clearing_q;
	logic [pcbqh_pkg::CLR_AW-1:0] clr_cnt_q;

	logic                         v_s1;
	pcbqh_pkg::cmd_t              cmd_s1;

	logic                         out_valid_q;
	logic [2:0]                   status_q;
	logic [31:0]                  count_q;
	logic [pcbqh_pkg::YW-1:0]     yield_q;
	logic [pcbqh_pkg::RW-1:0]     reads_q;

	logic                         fbq_v_q;
	logic [pcbqh_pkg::BQ_AW-1:0]  fbq_addr_q;
	pcbqh_pkg::row_t              fbq_data_q;
	logic                         flh_v_q;
	logic [pcbqh_pkg::LH_AW-1:0]  flh_addr_q;
	pcbqh_pkg::count_t            flh_data_q;

	logic                         adv1;
	logic                         pop_fire;
	logic [BQ_W-1:0]              bq_rdata;
	pcbqh_pkg::count_t            lh_rdata;
	pcbqh_pkg::row_t              bq_row;
	pcbqh_pkg::row_t              bq_new;
	pcbqh_pkg::count_t            bq_cur;
	pcbqh_pkg::count_t            bq_inc;
	pcbqh_pkg::count_t            lh_cur;
	pcbqh_pkg::count_t            lh_inc;
	pcbqh_pkg::count_t            cnt_sel;
	logic                         bq_cmd_we;
	logic                         lh_cmd_we;
	logic                         bq_we;
	logic                         lh_we;
	logic [pcbqh_pkg::BQ_AW-1:0]  bq_waddr;
	logic [pcbqh_pkg::LH_AW-1:0]  lh_waddr;
	logic [BQ_W-1:0]              bq_wdata;
	pcbqh_pkg::count_t            lh_wdata;

	assign clearing    = clearing_q;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign count_value = count_q;
	assign total_yield = yield_q;
	assign read_count  = reads_q;

	always_comb begin
		adv1      = v_s1 && (!out_valid_q || out_ready);
		pop_ready = !clearing_q && (!v_s1 || adv1);
		pop_fire  = pop_valid && pop_ready;

		// forward the last write; the RAM returns old data on a collision
		bq_row = (fbq_v_q && fbq_addr_q == cmd_s1.bq_row) ? fbq_data_q : bq_rdata;
		lh_cur = (flh_v_q && flh_addr_q == cmd_s1.lh_addr) ? flh_data_q : lh_rdata;

		bq_cur = bq_row[cmd_s1.lane];
		bq_inc = pcbqh_pkg::sat_inc(bq_cur);
		bq_new = bq_row;
		bq_new[cmd_s1.lane] = bq_inc;
		lh_inc = pcbqh_pkg::sat_inc(lh_cur);

		case (cmd_s1.kind)
			pcbqh_pkg::K_BQ_RD: cnt_sel = bq_cur;
			pcbqh_pkg::K_LH_RD: cnt_sel = lh_cur;
			default:            cnt_sel = '0;
		endcase

		bq_cmd_we = adv1 && cmd_s1.kind == pcbqh_pkg::K_BQ_INC;
		lh_cmd_we = adv1 && cmd_s1.kind == pcbqh_pkg::K_LH_INC;

		if (clearing_q) begin
			bq_we    = 32'(clr_cnt_q) < 32'(pcbqh_pkg::BQ_ROWS);
			lh_we    = 32'(clr_cnt_q) < 32'(pcbqh_pkg::LH_DEPTH);
			bq_waddr = pcbqh_pkg::BQ_AW'(clr_cnt_q);
			lh_waddr = pcbqh_pkg::LH_AW'(clr_cnt_q);
			bq_wdata = '0;
			lh_wdata = '0;
		end else begin
			bq_we    = bq_cmd_we;
			lh_we    = lh_cmd_we;
			bq_waddr = cmd_s1.bq_row;
			lh_waddr = cmd_s1.lh_addr;
			bq_wdata = bq_new;
			lh_wdata = lh_inc;
		end
	end

	pcbqh_ram #(
		.WIDTH (BQ_W),
		.DEPTH (pcbqh_pkg::BQ_ROWS)
	) u_bq_ram (
		.clk   (clk),
		.we    (bq_we),
		.waddr (bq_waddr),
		.wdata (bq_wdata),
		.re    (pop_fire),
		.raddr (pop_cmd.bq_row),
		.rdata (bq_rdata)
	);

	pcbqh_ram #(
		.WIDTH (pcbqh_pkg::COUNT_WIDTH),
		.DEPTH (pcbqh_pkg::LH_DEPTH)
	) u_lh_ram (
		.clk   (clk),
		.we    (lh_we),
		.waddr (lh_waddr),
		.wdata (lh_wdata),
		.re    (pop_fire),
		.raddr (pop_cmd.lh_addr),
		.rdata (lh_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			fbq_v_q     <= 1'b0;
			flh_v_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + pcbqh_pkg::CLR_AW'(1);
				if (clr_cnt_q == pcbqh_pkg::CLR_AW'(pcbqh_pkg::CLR_ROWS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (adv1 || pop_fire) begin
				v_s1 <= pop_fire;
			end
			if (adv1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (bq_cmd_we) begin
				fbq_v_q <= 1'b1;
			end
			if (lh_cmd_we) begin
				flh_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			cmd_s1 <= pop_cmd;
		end
		if (adv1) begin
			status_q <= 3'(cmd_s1.status);
			count_q  <= 32'(cnt_sel);
			yield_q  <= cmd_s1.yield;
			reads_q  <= cmd_s1.reads;
		end
		if (bq_cmd_we) begin
			fbq_addr_q <= cmd_s1.bq_row;
			fbq_data_q <= bq_new;
		end
		if (lh_cmd_we) begin
			flh_addr_q <= cmd_s1.lh_addr;
			flh_data_q <= lh_inc;
		end
	end

`ifndef SYNTHESIS
	a_idle_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !v_s1 && !out_valid_q)
		else $error("work in flight during memory clear");

	a_bq_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		bq_cmd_we |-> bq_inc >= bq_cur)
		else $error("bin counter wrapped");

	a_lh_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		lh_cmd_we |-> lh_inc >= lh_cur)
		else $error("length counter wrapped");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && cmd_s1.status != pcbqh_pkg::ST_OK |=> out_valid_q && count_q == '0)
		else $error("error result carries a count");
`endif

endmodule
`default_nettype wire

[rtl/core/per_cycle_base_quality_histogram_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_cycle_base_quality_histogram_top: per-cycle base/quality histogram
// Counts bases per read end, position, quality score and base code, keeps a
// read-length histogram, yields and a pair count, and answers bin queries.
// ----------------------------------------------------------------------------
//
//  channel  signals                              dir  transfer when
//  -------  -----------------------------------  ---  ----------------------
//  cfg      cfg_we, cfg_wdata (quality offset)   in   cfg_we high
//  in       in_valid/in_ready + opcode..length   in   in_valid && in_ready
//  out      out_valid/out_ready + status..count  out  out_valid && out_ready
//
// One item per clock sustained while the output is not stalled; out_valid
// rises after the input transfer passes the queue write, the bin memory read
// and the result register.
// Rate is set by the bin memory read-modify-write: one read and one write
// port per cycle, with the last write forwarded to the following item.
// After reset both count memories are swept to zero, one row per cycle;
// in_ready stays low meanwhile, configuration writes are still taken.
// A stalled output still takes six transfers (result register, memory stage,
// four-entry queue) before in_ready drops.
//
module per_cycle_base_quality_histogram_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	// input items
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic        read_end,
	input  wire logic [7:0]  base_char,
	input  wire logic [7:0]  qual_char,
	input  wire logic [7:0]  query_cycle,
	input  wire logic [5:0]  query_quality,
	input  wire logic [2:0]  query_base,
	input  wire logic [8:0]  query_length,
	// results
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [31:0]      count_value,
	output logic [47:0]      total_yield,
	output logic [31:0]      read_count
);

	logic            clearing;
	logic            push_valid;
	logic            push_ready;
	pcbqh_pkg::cmd_t push_cmd;
	logic            pop_valid;
	logic            pop_ready;
	pcbqh_pkg::cmd_t pop_cmd;

	// front: decode, error checks, per-read counters and totals
	pcbqh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.read_end      (read_end),
		.base_char     (base_char),
		.qual_char     (qual_char),
		.query_cycle   (query_cycle),
		.query_quality (query_quality),
		.query_base    (query_base),
		.query_length  (query_length),
		.clearing      (clearing),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_cmd      (push_cmd)
	);

	// queue decouples decode from memory stalls
	pcbqh_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// back: bin memories, RMW with forwarding, result register
	pcbqh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_cmd     (pop_cmd),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.count_value (count_value),
		.total_yield (total_yield),
		.read_count  (read_count)
	);

endmodule
`default_nettype wire
